>>> src/kdlp_pkg.sv
// Shared types, codes and helpers for the key debounce / long-press scanner.
package kdlp_pkg;

    // Width of the long-press threshold register
    localparam int TICKS_W = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_LONG_TICKS    = 2'd0;
    localparam logic [1:0] CFG_PRESSED_LEVEL = 2'd1;
    localparam logic [1:0] CFG_SHIELD        = 2'd2;

    // Reset value of the threshold
    localparam logic [TICKS_W-1:0] LONG_TICKS_RST = 16'd100;

    // Reported key state codes
    localparam logic [1:0] KS_IDLE    = 2'd0;
    localparam logic [1:0] KS_CONFIRM = 2'd1;
    localparam logic [1:0] KS_DOWN    = 2'd2;
    localparam logic [1:0] KS_LONG    = 2'd3;

    // Scanner state, one-hot
    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_CONFIRM = 4'b0010,
        S_DOWN    = 4'b0100,
        S_LONG    = 4'b1000
    } t_state;

    // Key event codes
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_LONG    = 2'd2,
        EV_RELEASE = 2'd3
    } t_event;

    // Configuration registers
    typedef struct packed {
        logic [TICKS_W-1:0] long_press_ticks;
        logic               pressed_level;
        logic               shield;
    } t_cfg;

    // One result item
    typedef struct packed {
        t_event     key_event;
        logic [1:0] key_state;
        logic       pressed_now;
    } t_result;

    // One-hot state to reported code
    function automatic logic [1:0] state_code(input t_state s);
        logic [1:0] c;
        case (s)
            S_IDLE:    c = KS_IDLE;
            S_CONFIRM: c = KS_CONFIRM;
            S_DOWN:    c = KS_DOWN;
            S_LONG:    c = KS_LONG;
            default:   c = KS_IDLE;
        endcase
        return c;
    endfunction

endpackage

>>> src/key_debounce_long_press.sv
// A result is registered in the output register when its input transaction is taken.
// Throughput: one scan tick per cycle unless the output stalls; the state update loops
// via the state and hold counter registers. A new transaction is taken in the cycle a waiting
// result drains; a stalled result holds off the input. Synchronous active-low reset: state
// idle, hold count 0, threshold 100, pressed level 0, shield off, output empty.
// Top level of the debounced key scanner with long-press repeat.
module key_debounce_long_press #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_pin_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_key_event,
    output logic [1:0]  o_key_state,
    output logic        o_pressed_now,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import kdlp_pkg::*;

    t_cfg                   cfg;
    t_state                 r_state;
    t_state                 n_state;
    logic [COUNT_WIDTH-1:0] r_hold;
    logic [COUNT_WIDTH-1:0] n_hold;
    t_result                n_result;
    t_result                r_result;
    logic                   r_out_valid;
    logic                   in_accept;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    kdlp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Per-tick logic
    kdlp_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_state     (r_state),
        .i_hold      (r_hold),
        .i_pin_level (i_pin_level),
        .i_cfg       (cfg),
        .o_state     (n_state),
        .o_hold      (n_hold),
        .o_result    (n_result)
    );

    // Take a new tick whenever the output register is free or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // Scanner state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
                r_hold  <= n_hold;
            end
            if (in_accept) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) r_result <= n_result;
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_event   = r_result.key_event;
    assign o_key_state   = r_result.key_state;
    assign o_pressed_now = r_result.pressed_now;

endmodule

>>> src/kdlp_cfg.sv
// Configuration register file of the key scanner.
module kdlp_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [1:0]    i_wr_index,
    input  logic [15:0]   i_wr_data,
    output kdlp_pkg::t_cfg o_cfg
);
    import kdlp_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write transaction
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                CFG_LONG_TICKS:    n_cfg.long_press_ticks = i_wr_data[TICKS_W-1:0];
                CFG_PRESSED_LEVEL: n_cfg.pressed_level    = i_wr_data[0];
                CFG_SHIELD:        n_cfg.shield           = i_wr_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks <= LONG_TICKS_RST;
            r_cfg.pressed_level    <= 1'b0;
            r_cfg.shield           <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/kdlp_step.sv
// Next-state, hold counter and event logic for one scan tick.
module kdlp_step #(
    parameter int COUNT_WIDTH = 16
) (
    input  kdlp_pkg::t_state    i_state,
    input  logic [COUNT_WIDTH-1:0] i_hold,
    input  logic                i_pin_level,
    input  kdlp_pkg::t_cfg      i_cfg,
    output kdlp_pkg::t_state    o_state,
    output logic [COUNT_WIDTH-1:0] o_hold,
    output kdlp_pkg::t_result   o_result
);
    import kdlp_pkg::*;

    // Compare width covers both the counter and the threshold
    localparam int CMP_W = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;

    logic [COUNT_WIDTH-1:0] hold_inc;
    logic [CMP_W-1:0]       hold_ext;
    logic [CMP_W-1:0]       ticks_ext;
    logic                   reached;
    logic [COUNT_WIDTH-1:0] hold_after;
    logic                   pressed;
    t_state                 next_state;
    t_event                 ev;

    // Hold counter: wrap within the counter width, clear at threshold
    assign hold_inc   = i_hold + COUNT_WIDTH'(1);
    assign hold_ext   = CMP_W'(hold_inc);
    assign ticks_ext  = CMP_W'(i_cfg.long_press_ticks);
    assign reached    = (hold_ext >= ticks_ext);
    assign hold_after = reached ? '0 : hold_inc;

    assign pressed = !i_cfg.shield && (i_pin_level == i_cfg.pressed_level);

    // Scanner state machine
    always_comb begin
        next_state = i_state;
        o_hold     = i_hold;
        ev         = EV_NONE;
        if (i_cfg.shield) begin
            next_state = S_IDLE;
        end else begin
            case (i_state)
                S_IDLE: begin
                    if (pressed) next_state = S_CONFIRM;
                end
                S_CONFIRM: begin
                    if (pressed) begin
                        next_state = S_DOWN;
                        ev         = EV_PRESS;
                        o_hold     = '0;
                    end else begin
                        next_state = S_IDLE;
                    end
                end
                S_DOWN: begin
                    if (!pressed) begin
                        next_state = S_IDLE;
                        ev         = EV_RELEASE;
                    end else begin
                        o_hold = hold_after;
                        if (reached) begin
                            next_state = S_LONG;
                            ev         = EV_LONG;
                        end
                    end
                end
                S_LONG: begin
                    // release from long hold gives no event
                    if (!pressed) begin
                        next_state = S_IDLE;
                    end else begin
                        o_hold = hold_after;
                        if (reached) ev = EV_LONG;
                    end
                end
                default: next_state = S_IDLE;
            endcase
        end
    end

    assign o_state              = next_state;
    assign o_result.key_event   = ev;
    assign o_result.key_state   = state_code(next_state);
    assign o_result.pressed_now = pressed;

endmodule

>>> src/kdlp_checker.sv
// Port-level checker for the key scanner, bound to the top level.
module kdlp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_key_event,
    input logic [1:0] o_key_state,
    input logic       o_pressed_now
);
    import kdlp_pkg::*;

    // A stalled result transaction keeps its valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result valid dropped while stalled");

    // A press event always lands in the down state
    a_press_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_key_event == EV_PRESS |-> o_key_state == KS_DOWN)
        else $error("press event outside down state");

    // A long event always lands in the long held state
    a_long_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_key_event == EV_LONG |-> o_key_state == KS_LONG)
        else $error("long event outside long held state");

    // A release event returns to idle
    a_release_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_key_event == EV_RELEASE |-> o_key_state == KS_IDLE)
        else $error("release event not in idle state");

    // A tick without a pressed sample always leaves the scanner idle
    a_unpressed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pressed_now |-> o_key_state == KS_IDLE)
        else $error("unpressed tick left scanner active");

endmodule

bind key_debounce_long_press kdlp_checker u_kdlp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_key_event   (o_key_event),
    .o_key_state   (o_key_state),
    .o_pressed_now (o_pressed_now)
);
